/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/pps_pkg.sv */
`timescale 1ns / 1ps

package pps_pkg;

    localparam int SLOT_W        = 4;
    localparam int PRI_W         = 8;
    localparam int TM_W          = 16;
    localparam int TIME_W        = 24;
    localparam int CFG_W         = 5;
    localparam int CNT_W         = 5;
    localparam int MAX_PROCS_DEF = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 5'd31;
    localparam logic [CFG_W-1:0]  PC_RST   = 5'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic            found;
        logic [TM_W-1:0] arr;
        logic [TM_W-1:0] burst;
        logic [TM_W-1:0] rem;
    } t_scan_res;

    typedef struct packed {
        logic             load;
        logic             dec;
        logic [PRI_W-1:0] pri;
        logic [TM_W-1:0]  arr;
        logic [TM_W-1:0]  burst;
        logic [TM_W-1:0]  rem;
    } t_wr_req;

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

/* hw/rtl/preemptive_priority_scheduler_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_op i_slot i_priority_req
//                                                  i_arrival_time i_burst_time
// out       output     o_out_valid / i_out_ready   o_ran_slot o_idle o_finished
//                                                  o_completion_time o_waiting_time
//                                                  o_turnaround_time o_all_done
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (process_count)
//
// Load item: no result.
// Tick item: the scan covers n = min(process_count, MAX_PROCS) slots and reads
// one slot a cycle from the slot memory through one shared compare unit.
// Reset clears time, finished count and control; process_count resets to 1.
// A tick result waits in the output register; the next tick holds in its last
// step until that register is free.

`include "assert_macros.svh"

module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [pps_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pps_pkg::PRI_W-1:0]   i_priority_req,
    input  logic [pps_pkg::TM_W-1:0]    i_arrival_time,
    input  logic [pps_pkg::TM_W-1:0]    i_burst_time,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pps_pkg::SLOT_W-1:0]  o_ran_slot,
    output logic                        o_idle,
    output logic                        o_finished,
    output logic [pps_pkg::TIME_W-1:0]  o_completion_time,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting_time,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround_time,
    output logic                        o_all_done,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pps_pkg::CFG_W-1:0]   i_cfg_data
);
    import pps_pkg::*;

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_UPD  = 6'b000100,
        S_TURN = 6'b001000,
        S_WAIT = 6'b010000,
        S_POST = 6'b100000
    } t_state;

    t_state             r_state, n_state;

    logic [CFG_W-1:0]   r_pc;
    logic [TIME_W-1:0]  r_tick;
    logic [CNT_W-1:0]   r_fcnt, n_fcnt;
    logic               r_out_valid;

    logic               r_found;
    logic               r_fin;
    logic [IW-1:0]      r_slot;
    logic [TM_W-1:0]    r_arr;
    logic [TM_W-1:0]    r_burst;
    logic [TIME_W-1:0]  r_comp;
    logic [TIME_W-1:0]  r_turn;
    logic [TIME_W-1:0]  r_wait;

    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_idle;
    logic               r_o_fin;
    logic [TIME_W-1:0]  r_o_comp;
    logic [TIME_W-1:0]  r_o_wait;
    logic [TIME_W-1:0]  r_o_turn;
    logic               r_o_all;

    logic               in_acc;
    logic               slot_ok;
    logic               start;
    logic               post_go;
    logic [CW-1:0]      n_eff;
    t_wr_req            wr;
    logic [IW-1:0]      wr_addr;
    logic               scan_done;
    t_scan_res          scan_res;
    logic [IW-1:0]      best_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_ok     = (32'(i_slot) < 32'(MAX_PROCS));
    assign start       = in_acc && (i_op == OP_TICK);
    assign post_go     = (r_state == S_POST) && (!r_out_valid || i_out_ready);
    assign n_eff       = (32'(r_pc) > 32'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(r_pc);
    assign n_fcnt      = (r_fin && (r_fcnt != CNT_MAX)) ? r_fcnt + CNT_W'(1) : r_fcnt;

    always_comb begin
        wr.load  = in_acc && (i_op == OP_LOAD) && slot_ok;
        wr.dec   = (r_state == S_UPD) && scan_res.found;
        wr.pri   = i_priority_req;
        wr.arr   = i_arrival_time;
        wr.burst = i_burst_time;
        wr.rem   = wr.dec ? scan_res.rem - TM_W'(1) : i_burst_time;
        wr_addr  = (r_state == S_UPD) ? best_idx : IW'(i_slot);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_SCAN;
            S_SCAN: if (scan_done) n_state = S_UPD;
            S_UPD:  n_state = S_TURN;
            S_TURN: n_state = S_WAIT;
            S_WAIT: n_state = S_POST;
            S_POST: if (post_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    pps_scan_core #(
        .MAX_PROCS (MAX_PROCS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_wr_addr  (wr_addr),
        .i_start    (start),
        .i_n        (n_eff),
        .i_tick     (r_tick),
        .o_done     (scan_done),
        .o_res      (scan_res),
        .o_best_idx (best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PC_RST;
            r_tick      <= '0;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_pc <= i_cfg_data;
            end
            if (r_state == S_UPD) begin
                r_found <= scan_res.found;
                r_fin   <= scan_res.found && (scan_res.rem == TM_W'(1));
            end
            if (post_go) begin
                r_out_valid <= 1'b1;
                r_fcnt      <= n_fcnt;
                if (r_tick != TIME_MAX) begin
                    r_tick <= r_tick + TIME_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_UPD: begin
                r_slot  <= best_idx;
                r_arr   <= scan_res.arr;
                r_burst <= scan_res.burst;
                r_comp  <= (r_tick != TIME_MAX) ? r_tick + TIME_W'(1) : TIME_MAX;
            end
            S_TURN: r_turn <= sat_sub(r_comp, {{(TIME_W-TM_W){1'b0}}, r_arr});
            S_WAIT: r_wait <= sat_sub(r_turn, {{(TIME_W-TM_W){1'b0}}, r_burst});
            default: ;
        endcase
        if (post_go) begin
            r_o_slot <= r_found ? SLOT_W'(r_slot) : '0;
            r_o_idle <= !r_found;
            r_o_fin  <= r_fin;
            r_o_comp <= r_fin ? r_comp : '0;
            r_o_turn <= r_fin ? r_turn : '0;
            r_o_wait <= r_fin ? r_wait : '0;
            r_o_all  <= (n_fcnt == r_pc);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ran_slot        = r_o_slot;
    assign o_idle            = r_o_idle;
    assign o_finished        = r_o_fin;
    assign o_completion_time = r_o_comp;
    assign o_waiting_time    = r_o_wait;
    assign o_turnaround_time = r_o_turn;
    assign o_all_done        = r_o_all;

    `ASSERT_RST(a_tick_starts_scan, i_clk, i_rst_n, (in_acc && (i_op == OP_TICK)) |=> (r_state == S_SCAN), "tick item did not start a scan")
    `ASSERT_RST(a_idle_clean, i_clk, i_rst_n, (o_out_valid && o_idle) |-> (!o_finished && (o_ran_slot == '0)), "idle result carries a slot or completion")
    `ASSERT_RST(a_wait_le_turn, i_clk, i_rst_n, (o_out_valid && o_finished) |-> (o_turnaround_time >= o_waiting_time), "waiting time above turnaround time")
    `ASSERT_CLK(a_tick_monotonic, i_clk, (i_rst_n && $past(i_rst_n)) |-> (r_tick >= $past(r_tick)), "time counter went backward")

endmodule

/* hw/rtl/pps_scan_core.sv */
`timescale 1ns / 1ps

module pps_scan_core #(
    parameter int   MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
    localparam int  IW        = $clog2(MAX_PROCS),
    localparam int  CW        = $clog2(MAX_PROCS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_wr_req            i_wr,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic                        i_start,
    input  logic [CW-1:0]               i_n,
    input  logic [pps_pkg::TIME_W-1:0]  i_tick,
    output logic                        o_done,
    output pps_pkg::t_scan_res          o_res,
    output logic [IW-1:0]               o_best_idx
);
    import pps_pkg::*;

    logic [PRI_W-1:0] mem_pri   [MAX_PROCS];
    logic [TM_W-1:0]  mem_arr   [MAX_PROCS];
    logic [TM_W-1:0]  mem_burst [MAX_PROCS];
    logic [TM_W-1:0]  mem_rem   [MAX_PROCS];

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_n;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic             r_found;

    logic [PRI_W-1:0] r_rd_pri;
    logic [TM_W-1:0]  r_rd_arr;
    logic [TM_W-1:0]  r_rd_burst;
    logic [TM_W-1:0]  r_rd_rem;

    logic [PRI_W-1:0] r_best_pri;
    logic [TM_W-1:0]  r_best_arr;
    logic [TM_W-1:0]  r_best_burst;
    logic [TM_W-1:0]  r_best_rem;
    logic [IW-1:0]    r_best_idx;

    logic             rd_en;
    logic             elig;
    logic             take;

    assign rd_en = r_busy && (r_idx < r_n);
    assign elig  = ({{(TIME_W-TM_W){1'b0}}, r_rd_arr} <= i_tick) && (r_rd_rem != '0);
    assign take  = r_busy && r_cmp_vld && elig && (!r_found || (r_rd_pri > r_best_pri));

    always_ff @(posedge i_clk) begin
        if (i_wr.load) begin
            mem_pri[i_wr_addr]   <= i_wr.pri;
            mem_arr[i_wr_addr]   <= i_wr.arr;
            mem_burst[i_wr_addr] <= i_wr.burst;
        end
        if (i_wr.load || i_wr.dec) begin
            mem_rem[i_wr_addr] <= i_wr.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_pri   <= mem_pri[r_idx[IW-1:0]];
            r_rd_arr   <= mem_arr[r_idx[IW-1:0]];
            r_rd_burst <= mem_burst[r_idx[IW-1:0]];
            r_rd_rem   <= mem_rem[r_idx[IW-1:0]];
            r_cmp_idx  <= r_idx[IW-1:0];
        end
        if (take) begin
            r_best_pri   <= r_rd_pri;
            r_best_arr   <= r_rd_arr;
            r_best_burst <= r_rd_burst;
            r_best_rem   <= r_rd_rem;
            r_best_idx   <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
            r_n       <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_idx     <= '0;
                r_n       <= i_n;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (r_busy) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
                if (!rd_en && !r_cmp_vld) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_best_idx  = r_best_idx;
    assign o_res.found = r_found;
    assign o_res.arr   = r_best_arr;
    assign o_res.burst = r_best_burst;
    assign o_res.rem   = r_best_rem;

endmodule
